>>> hw/rtl/pcse_pkg.sv
// shared types, opcodes and lookup tables for the pulse channel
// no dependencies

package pcse_pkg;

  typedef enum logic [3:0] {
    OpCtrl     = 4'd0,
    OpSweep    = 4'd1,
    OpTimerLo  = 4'd2,
    OpTimerHi  = 4'd3,
    OpEnable   = 4'd4,
    OpTimerTk  = 4'd5,
    OpEnvTk    = 4'd6,
    OpSweepTk  = 4'd7,
    OpLengthTk = 4'd8
  } op_e;

  localparam logic [15:0] PeriodMax   = 16'h07FF;
  localparam logic [15:0] PeriodMin   = 16'd8;
  localparam logic [15:0] HighMask    = 16'hFF00;
  localparam logic [15:0] LowMask     = 16'h00FF;
  localparam logic [3:0]  EnvFull     = 4'd15;
  localparam logic [1:0]  ChannelOne  = 2'd1;

  function automatic logic duty_bit(input logic [1:0] mode, input logic [2:0] step);
    logic [7:0] wave;
    case (mode)
      2'd0: wave = 8'b0000_0010;
      2'd1: wave = 8'b0000_0110;
      2'd2: wave = 8'b0001_1110;
      2'd3: wave = 8'b1111_1001;
      default: wave = 8'b0000_0000;
    endcase
    return wave[step];
  endfunction

  function automatic logic [7:0] length_load(input logic [4:0] idx);
    logic [7:0] v;
    case (idx)
      5'd0:  v = 8'd10;   5'd1:  v = 8'd254;  5'd2:  v = 8'd20;   5'd3:  v = 8'd2;
      5'd4:  v = 8'd40;   5'd5:  v = 8'd4;    5'd6:  v = 8'd80;   5'd7:  v = 8'd6;
      5'd8:  v = 8'd160;  5'd9:  v = 8'd8;    5'd10: v = 8'd60;   5'd11: v = 8'd10;
      5'd12: v = 8'd14;   5'd13: v = 8'd12;   5'd14: v = 8'd26;   5'd15: v = 8'd14;
      5'd16: v = 8'd12;   5'd17: v = 8'd16;   5'd18: v = 8'd24;   5'd19: v = 8'd18;
      5'd20: v = 8'd48;   5'd21: v = 8'd20;   5'd22: v = 8'd96;   5'd23: v = 8'd22;
      5'd24: v = 8'd192;  5'd25: v = 8'd24;   5'd26: v = 8'd72;   5'd27: v = 8'd26;
      5'd28: v = 8'd16;   5'd29: v = 8'd28;   5'd30: v = 8'd32;   5'd31: v = 8'd30;
      default: v = 8'd0;
    endcase
    return v;
  endfunction

endpackage

>>> hw/rtl/pcse_core.sv
// channel state: timer, duty step, envelope, sweep and length counter
// applies one operation per step and gives the sample of the updated state
// depends on pcse_pkg

module pcse_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic [3:0] opcode_i,
  input  logic [7:0] data_i,
  input  logic [1:0] channel_id_i,
  output logic [3:0] sample_o
);

  logic [1:0]  duty_mode_q, duty_mode_d;
  logic [2:0]  duty_step_q, duty_step_d;
  logic        length_halt_n_q, length_halt_n_d;
  logic        env_loop_q, env_loop_d;
  logic        env_use_q, env_use_d;
  logic [3:0]  env_reload_q, env_reload_d;
  logic [3:0]  fixed_volume_q, fixed_volume_d;
  logic        env_restart_q, env_restart_d;
  logic [3:0]  env_level_q, env_level_d;
  logic [3:0]  env_divider_q, env_divider_d;
  logic        sweep_on_q, sweep_on_d;
  logic [3:0]  sweep_reload_q, sweep_reload_d;
  logic        sweep_down_q, sweep_down_d;
  logic [2:0]  sweep_amount_q, sweep_amount_d;
  logic        sweep_restart_q, sweep_restart_d;
  logic [3:0]  sweep_divider_q, sweep_divider_d;
  logic [15:0] period_q, period_d;
  logic [15:0] period_count_q, period_count_d;
  logic [7:0]  length_count_q, length_count_d;
  logic        chan_on_q, chan_on_d;

  logic [15:0] sweep_delta;
  logic [15:0] swept_period;

  assign sweep_delta  = period_q >> sweep_amount_q;
  assign swept_period = sweep_down_q
                      ? (period_q - sweep_delta
                         - {15'd0, channel_id_i == pcse_pkg::ChannelOne})
                      : (period_q + sweep_delta);

  always_comb begin
    duty_mode_d     = duty_mode_q;
    duty_step_d     = duty_step_q;
    length_halt_n_d = length_halt_n_q;
    env_loop_d      = env_loop_q;
    env_use_d       = env_use_q;
    env_reload_d    = env_reload_q;
    fixed_volume_d  = fixed_volume_q;
    env_restart_d   = env_restart_q;
    env_level_d     = env_level_q;
    env_divider_d   = env_divider_q;
    sweep_on_d      = sweep_on_q;
    sweep_reload_d  = sweep_reload_q;
    sweep_down_d    = sweep_down_q;
    sweep_amount_d  = sweep_amount_q;
    sweep_restart_d = sweep_restart_q;
    sweep_divider_d = sweep_divider_q;
    period_d        = period_q;
    period_count_d  = period_count_q;
    length_count_d  = length_count_q;
    chan_on_d       = chan_on_q;
    if (step_i) begin
      case (opcode_i)
        pcse_pkg::OpCtrl: begin
          duty_mode_d     = data_i[7:6];
          length_halt_n_d = ~data_i[5];
          env_loop_d      = data_i[5];
          env_use_d       = ~data_i[4];
          env_reload_d    = data_i[3:0];
          fixed_volume_d  = data_i[3:0];
          env_restart_d   = 1'b1;
        end
        pcse_pkg::OpSweep: begin
          sweep_on_d      = data_i[7];
          sweep_reload_d  = {1'b0, data_i[6:4]} + 4'd1;
          sweep_down_d    = data_i[3];
          sweep_amount_d  = data_i[2:0];
          sweep_restart_d = 1'b1;
        end
        pcse_pkg::OpTimerLo: begin
          period_d = (period_q & pcse_pkg::HighMask) | {8'd0, data_i};
        end
        pcse_pkg::OpTimerHi: begin
          length_count_d = pcse_pkg::length_load(data_i[7:3]);
          period_d       = (period_q & pcse_pkg::LowMask) | {5'd0, data_i[2:0], 8'd0};
          env_restart_d  = 1'b1;
          duty_step_d    = 3'd0;
        end
        pcse_pkg::OpEnable: begin
          chan_on_d = data_i[0];
        end
        pcse_pkg::OpTimerTk: begin
          if (period_count_q == 16'd0) begin
            period_count_d = period_q;
            duty_step_d    = duty_step_q + 3'd1;
          end else begin
            period_count_d = period_count_q - 16'd1;
          end
        end
        pcse_pkg::OpEnvTk: begin
          if (env_restart_q) begin
            env_level_d   = pcse_pkg::EnvFull;
            env_divider_d = env_reload_q;
            env_restart_d = 1'b0;
          end else if (env_divider_q != 4'd0) begin
            env_divider_d = env_divider_q - 4'd1;
          end else begin
            if (env_level_q != 4'd0) begin
              env_level_d = env_level_q - 4'd1;
            end else if (env_loop_q) begin
              env_level_d = pcse_pkg::EnvFull;
            end
            env_divider_d = env_reload_q;
          end
        end
        pcse_pkg::OpSweepTk: begin
          if (sweep_restart_q) begin
            if (sweep_on_q && sweep_divider_q == 4'd0) begin
              period_d = swept_period;
            end
            sweep_divider_d = sweep_reload_q;
            sweep_restart_d = 1'b0;
          end else if (sweep_divider_q != 4'd0) begin
            sweep_divider_d = sweep_divider_q - 4'd1;
          end else begin
            if (sweep_on_q) begin
              period_d = swept_period;
            end
            sweep_divider_d = sweep_reload_q;
          end
        end
        pcse_pkg::OpLengthTk: begin
          if (length_halt_n_q && length_count_q != 8'd0) begin
            length_count_d = length_count_q - 8'd1;
          end
        end
        default: ;
      endcase
    end
  end

  // output gating on the updated state
  always_comb begin
    if (!chan_on_d || length_count_d == 8'd0 ||
        !pcse_pkg::duty_bit(duty_mode_d, duty_step_d) ||
        period_d < pcse_pkg::PeriodMin || period_d > pcse_pkg::PeriodMax) begin
      sample_o = 4'd0;
    end else begin
      sample_o = env_use_d ? env_level_d : fixed_volume_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      duty_mode_q     <= '0;
      duty_step_q     <= '0;
      length_halt_n_q <= 1'b0;
      env_loop_q      <= 1'b0;
      env_use_q       <= 1'b0;
      env_reload_q    <= '0;
      fixed_volume_q  <= '0;
      env_restart_q   <= 1'b0;
      env_level_q     <= '0;
      env_divider_q   <= '0;
      sweep_on_q      <= 1'b0;
      sweep_reload_q  <= '0;
      sweep_down_q    <= 1'b0;
      sweep_amount_q  <= '0;
      sweep_restart_q <= 1'b0;
      sweep_divider_q <= '0;
      period_q        <= '0;
      period_count_q  <= '0;
      length_count_q  <= '0;
      chan_on_q       <= 1'b0;
    end else begin
      duty_mode_q     <= duty_mode_d;
      duty_step_q     <= duty_step_d;
      length_halt_n_q <= length_halt_n_d;
      env_loop_q      <= env_loop_d;
      env_use_q       <= env_use_d;
      env_reload_q    <= env_reload_d;
      fixed_volume_q  <= fixed_volume_d;
      env_restart_q   <= env_restart_d;
      env_level_q     <= env_level_d;
      env_divider_q   <= env_divider_d;
      sweep_on_q      <= sweep_on_d;
      sweep_reload_q  <= sweep_reload_d;
      sweep_down_q    <= sweep_down_d;
      sweep_amount_q  <= sweep_amount_d;
      sweep_restart_q <= sweep_restart_d;
      sweep_divider_q <= sweep_divider_d;
      period_q        <= period_d;
      period_count_q  <= period_count_d;
      length_count_q  <= length_count_d;
      chan_on_q       <= chan_on_d;
    end
  end

endmodule

>>> hw/rtl/pulse_channel_sweep_envelope.sv
// top level of the pulse sound channel: input register, channel core, result register
// depends on pcse_pkg and pcse_core
//
// usage:
//   input channel: opcode_i / data_byte_i with in_valid_i, in_stall_o. a transfer
//   happens on a rising edge with in_valid_i high and in_stall_o low.
//   output channel: sample_o with out_valid_o, out_stall_i, one sample per operation.
//   config channel: cfg_channel_id_i with cfg_valid_i, cfg_ready_o (always ready);
//   write it only while no operation is in flight.
//   the sample register loads at the first rising edge after
//   the transfer when the output is free, and out_valid_o is high from then on.
//   throughput: one operation per cycle while the output is not stalled; the core
//   applies it combinationally between the input register and the sample register.
//   reset: all channel state clears, channel id returns to 1, both registers empty.
//   stall: while out_stall_i holds a waiting sample, the input register keeps
//   one more operation and then in_stall_o rises; nothing is dropped.

module pulse_channel_sweep_envelope (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [3:0] opcode_i,
  input  logic [7:0] data_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [3:0] sample_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [1:0] cfg_channel_id_i
);

  logic       s1_valid_q, s1_valid_d;
  logic [3:0] s1_op_q;
  logic [7:0] s1_data_q;
  logic       out_valid_q, out_valid_d;
  logic [3:0] sample_q;
  logic [1:0] channel_id_q;
  logic [3:0] core_sample;
  logic       advance;
  logic       in_fire;

  assign advance     = !out_valid_q || !out_stall_i;
  assign in_stall_o  = s1_valid_q && !advance;
  assign in_fire     = in_valid_i && !in_stall_o;
  assign s1_valid_d  = in_stall_o ? s1_valid_q : in_valid_i;
  assign out_valid_d = advance ? s1_valid_q : out_valid_q;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign sample_o    = sample_q;

  pcse_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (s1_valid_q && advance),
    .opcode_i     (s1_op_q),
    .data_i       (s1_data_q),
    .channel_id_i (channel_id_q),
    .sample_o     (core_sample)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      channel_id_q <= pcse_pkg::ChannelOne;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        channel_id_q <= cfg_channel_id_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_op_q   <= opcode_i;
      s1_data_q <= data_byte_i;
    end
    if (advance && s1_valid_q) begin
      sample_q <= core_sample;
    end
  end

endmodule

>>> dv/pcse_sample_check.sv
`timescale 1ns / 100ps
// sample checker for the pulse channel: follows every transfer, predicts each sample
// from its own copy of the channel state and compares in order; uses pcse_pkg

module pcse_sample_check
  import pcse_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_stall_i,
  input  logic [3:0] opcode_i,
  input  logic [7:0] data_byte_i,
  input  logic       out_valid_i,
  input  logic       out_stall_i,
  input  logic [3:0] sample_i,
  input  logic       cfg_valid_i,
  input  logic       cfg_ready_i,
  input  logic [1:0] cfg_channel_id_i,
  output int         fail_count_o,
  output int         pending_o
);

  // step 0 is the leftmost bit
  localparam logic [0:7] DutyWave [4] = '{
    8'b0100_0000, 8'b0110_0000, 8'b0111_1000, 8'b1001_1111
  };

  localparam logic [7:0] LengthTable [32] = '{
    8'd10,  8'd254, 8'd20, 8'd2,  8'd40,  8'd4,  8'd80, 8'd6,
    8'd160, 8'd8,   8'd60, 8'd10, 8'd14,  8'd12, 8'd26, 8'd14,
    8'd12,  8'd16,  8'd24, 8'd18, 8'd48,  8'd20, 8'd96, 8'd22,
    8'd192, 8'd24,  8'd72, 8'd26, 8'd16,  8'd28, 8'd32, 8'd30
  };

  logic [1:0]  chan_id;
  logic [1:0]  duty_mode;
  logic [2:0]  duty_step;
  logic        length_runs;
  logic        env_loop;
  logic        env_use;
  logic [3:0]  env_period;
  logic [3:0]  volume;
  logic        env_restart;
  logic [3:0]  env_level;
  logic [3:0]  env_div;
  logic        sweep_on;
  logic [3:0]  sweep_period;
  logic        sweep_down;
  logic [2:0]  sweep_shift;
  logic        sweep_restart;
  logic [3:0]  sweep_div;
  logic [15:0] period;
  logic [15:0] period_count;
  logic [7:0]  length_count;
  logic        chan_on;

  logic [3:0]  samples_due[$];
  logic [3:0]  want;
  int          fails;

  function automatic void clear_channel();
    chan_id = ChannelOne;
    duty_mode = '0; duty_step = '0; length_runs = 1'b0; env_loop = 1'b0;
    env_use = 1'b0; env_period = '0; volume = '0; env_restart = 1'b0;
    env_level = '0; env_div = '0; sweep_on = 1'b0; sweep_period = '0;
    sweep_down = 1'b0; sweep_shift = '0; sweep_restart = 1'b0; sweep_div = '0;
    period = '0; period_count = '0; length_count = '0; chan_on = 1'b0;
  endfunction

  function automatic void bend_period();
    logic [15:0] delta;
    delta = period >> sweep_shift;
    if (sweep_down) begin
      period = period - delta;
      if (chan_id == ChannelOne) period = period - 16'd1;
    end else begin
      period = period + delta;
    end
  endfunction

  function automatic logic [3:0] sample_after_op(input logic [3:0] op, input logic [7:0] d);
    case (op)
      OpCtrl: begin
        duty_mode = d[7:6];
        length_runs = ~d[5];
        env_loop = d[5];
        env_use = ~d[4];
        env_period = d[3:0];
        volume = d[3:0];
        env_restart = 1'b1;
      end
      OpSweep: begin
        sweep_on = d[7];
        sweep_period = {1'b0, d[6:4]} + 4'd1;
        sweep_down = d[3];
        sweep_shift = d[2:0];
        sweep_restart = 1'b1;
      end
      OpTimerLo: period = (period & HighMask) | {8'h00, d};
      OpTimerHi: begin
        length_count = LengthTable[d[7:3]];
        period = (period & LowMask) | {5'b0, d[2:0], 8'h00};
        env_restart = 1'b1;
        duty_step = '0;
      end
      OpEnable: chan_on = d[0];
      OpTimerTk: begin
        if (period_count == '0) begin
          period_count = period;
          duty_step = duty_step + 3'd1;
        end else begin
          period_count = period_count - 16'd1;
        end
      end
      OpEnvTk: begin
        if (env_restart) begin
          env_level = EnvFull;
          env_div = env_period;
          env_restart = 1'b0;
        end else if (env_div != '0) begin
          env_div = env_div - 4'd1;
        end else begin
          if (env_level != '0) env_level = env_level - 4'd1;
          else if (env_loop) env_level = EnvFull;
          env_div = env_period;
        end
      end
      OpSweepTk: begin
        if (sweep_restart) begin
          if (sweep_on && sweep_div == '0) bend_period();
          sweep_div = sweep_period;
          sweep_restart = 1'b0;
        end else if (sweep_div != '0) begin
          sweep_div = sweep_div - 4'd1;
        end else begin
          if (sweep_on) bend_period();
          sweep_div = sweep_period;
        end
      end
      OpLengthTk: begin
        if (length_runs && length_count != '0) length_count = length_count - 8'd1;
      end
      default: ;
    endcase
    if (!chan_on || length_count == '0) return 4'd0;
    if (!DutyWave[duty_mode][duty_step]) return 4'd0;
    if (period < PeriodMin || period > PeriodMax) return 4'd0;
    return env_use ? env_level : volume;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_channel();
      samples_due.delete();
      fails = 0;
      fail_count_o <= 0;
      pending_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) chan_id = cfg_channel_id_i;
      if (out_valid_i && !out_stall_i) begin
        if (samples_due.size() == 0) begin
          fails++;
          if (fails <= 10) begin
            $display("%0t ns: sample %0d arrived with nothing outstanding", $time, sample_i);
          end
        end else begin
          want = samples_due.pop_front();
          if (want !== sample_i) begin
            fails++;
            if (fails <= 10) begin
              $display("%0t ns: sample mismatch, expected %0d actual %0d",
                       $time, want, sample_i);
            end
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        samples_due.push_back(sample_after_op(opcode_i, data_byte_i));
      end
      fail_count_o <= fails;
      pending_o <= samples_due.size();
    end
  end

endmodule

>>> dv/tb.sv
`timescale 1ns / 100ps
// top of the pulse channel testbench: clock, reset, operation stimulus and output stalls
// depends on pcse_pkg, pulse_channel_sweep_envelope and pcse_sample_check

module tb;
  import pcse_pkg::*;

  localparam logic [3:0] OpUnusedLo   = 4'd9;
  localparam logic [3:0] OpUnusedHi   = 4'd15;
  localparam logic [1:0] ChannelTwo   = 2'd2;
  localparam int         HoldCycles   = 60;
  localparam int         QuietLimit   = 1000;
  localparam int         PhaseCount   = 6;
  localparam int         PhaseItems   = 290;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [3:0] opcode;
  logic [7:0] data_byte;
  logic       out_valid;
  logic       out_stall;
  logic [3:0] sample;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [1:0] cfg_channel_id;

  logic       calm;
  int         hold_asked;
  int         hold_seen;
  int         ops_sent;
  int         quiet_cycles;
  int         fail_count;
  int         pending;

  always #5 clk = ~clk;

  pulse_channel_sweep_envelope uut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .opcode_i         (opcode),
    .data_byte_i      (data_byte),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .sample_o         (sample),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_o      (cfg_ready),
    .cfg_channel_id_i (cfg_channel_id)
  );

  pcse_sample_check sample_check (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .opcode_i         (opcode),
    .data_byte_i      (data_byte),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .sample_i         (sample),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_i      (cfg_ready),
    .cfg_channel_id_i (cfg_channel_id),
    .fail_count_o     (fail_count),
    .pending_o        (pending)
  );

  task automatic send_op(input logic [3:0] op, input logic [7:0] d);
    while (!calm && $urandom_range(0, 99) < 21) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode <= op;
    data_byte <= d;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    ops_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_channel_id(input logic [1:0] id);
    cfg_valid <= 1'b1;
    cfg_channel_id <= id;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // output side: random stalls plus a long hold on request
  initial begin : receiver
    int held;
    out_stall <= 1'b0;
    hold_seen = 0;
    forever begin
      @(posedge clk);
      if (hold_asked != hold_seen) begin
        hold_seen = hold_asked;
        for (held = 0; held < HoldCycles; held++) begin
          out_stall <= 1'b1;
          @(posedge clk);
        end
      end
      out_stall <= !calm && ($urandom_range(0, 99) < 21);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QuietLimit) begin
      $display("no transfer for %0d cycles, %0d samples outstanding", QuietLimit, pending);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    int         phase;
    int         n;
    int         pick;
    logic [3:0] op;
    logic [7:0] d;
    in_valid <= 1'b0;
    opcode <= OpCtrl;
    data_byte <= 8'h00;
    cfg_valid <= 1'b0;
    cfg_channel_id <= ChannelOne;
    calm <= 1'b0;
    hold_asked <= 0;
    quiet_cycles <= 0;
    ops_sent = 0;
    rst_n = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    write_channel_id(ChannelOne);

    // full period, upward sweep past the period maximum, zero-shift negate to 0xFFFF, disable, unknown ops
    send_op(OpEnable, 8'h01);
    send_op(OpCtrl, 8'hFF);
    send_op(OpTimerLo, 8'hFF);
    send_op(OpTimerHi, 8'hFF);
    send_op(OpTimerTk, 8'h00);
    send_op(OpSweep, 8'h80);
    repeat (3) send_op(OpSweepTk, 8'h00);
    send_op(OpSweep, 8'h88);
    repeat (3) send_op(OpSweepTk, 8'hFF);
    send_op(OpSweep, 8'h7F);
    send_op(OpTimerHi, 8'h07);
    send_op(OpEnable, 8'hFE);
    send_op(OpEnable, 8'h01);
    send_op(OpCtrl, 8'h00);
    send_op(OpEnvTk, 8'hFF);
    send_op(OpEnvTk, 8'h00);
    send_op(OpLengthTk, 8'h00);
    send_op(OpTimerLo, 8'h00);
    send_op(OpUnusedLo, 8'hAA);
    send_op(OpUnusedHi, 8'h55);

    for (phase = 0; phase < PhaseCount; phase++) begin
      drain();
      if (phase == PhaseCount - 1) begin
        write_channel_id($urandom_range(0, 1) ? ChannelOne : ChannelTwo);
      end else begin
        write_channel_id(phase[0] ? ChannelOne : ChannelTwo);
      end
      calm <= (phase == 3);
      if (phase == 1 || phase == 4) hold_asked <= hold_asked + 1;
      for (n = 0; n < PhaseItems; n++) begin
        pick = $urandom_range(0, 99);
        d = 8'($urandom_range(0, 255));
        if (pick < 38) op = OpTimerTk;
        else if (pick < 48) op = OpEnvTk;
        else if (pick < 57) op = OpSweepTk;
        else if (pick < 65) op = OpLengthTk;
        else if (pick < 72) op = OpCtrl;
        else if (pick < 77) op = OpSweep;
        else if (pick < 82) op = OpTimerLo;
        else if (pick < 88) begin
          op = OpTimerHi;
          if (pick[0]) d[2:0] = 3'd0;
        end else if (pick < 94) begin
          op = OpEnable;
          d[0] = (pick != 88);
        end else begin
          op = 4'($urandom_range(OpUnusedLo, OpUnusedHi));
        end
        send_op(op, d);
      end
    end

    drain();
    repeat (4) @(posedge clk);
    $display("ran %0d operations over %0d channel-id settings (ids 1 and 2),", ops_sent,
             PhaseCount + 1);
    $display("with random idling on both sides and two %0d-cycle output holds", HoldCycles);
    if (fail_count == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
